### rtl/core/rsp_pkg.sv
// Shared widths, register codes, colours and carried-word structs for the
// ray-sphere pixel pipeline. No dependencies.
package rsp_pkg;

  localparam int IMG_WIDTH_DEF   = 512;
  localparam int IMG_HEIGHT_DEF  = 512;
  localparam int VIEW_WIDTH_DEF  = 1;
  localparam int VIEW_HEIGHT_DEF = 1;

  localparam int IN_W   = 24;
  localparam int OUT_W  = 72;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;
  localparam int ADDR_W = 18;

  localparam int VX_W   = 31;
  localparam int D_W    = 32;
  localparam int E_W    = 17;
  localparam int A_W    = 60;
  localparam int B_W    = 50;
  localparam int C_W    = 37;
  localparam int DISC_W = 100;
  localparam int SQ_W   = 48;
  localparam int SQ_RW  = 98;
  localparam int NUM_W  = 60;
  localparam int DEN_W  = 61;
  localparam int DQ_W   = 15;
  localparam int DIV_RW = 80;

  localparam logic [31:0] GREY_COLOR  = 32'hFF808080;
  localparam logic [31:0] LIGHT_COLOR = 32'h00FFDF00;

  typedef enum logic [CFG_AW-1:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_SPHERE_X,
    REG_SPHERE_Y,
    REG_SPHERE_Z,
    REG_SPHERE_RADIUS,
    REG_VIEW_DISTANCE
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [B_W-1:0]    b;
    logic [A_W-1:0]    a;
    logic              miss;
  } sq_side_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              neg;
    logic              ovf;
    logic              miss;
  } dv_side_t;

endpackage

### rtl/core/rsp_view_map.sv
// Three-stage map of one pixel coordinate onto the viewport plane (Q8).
// Depends on rsp_pkg.
module rsp_view_map import rsp_pkg::*; #(
  parameter int IMG  = IMG_WIDTH_DEF,
  parameter int VIEW = VIEW_WIDTH_DEF,
  parameter bit FLIP = 1'b0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [8:0]            coord,
  output logic signed [VX_W-1:0] v
);

  localparam int N_W   = 30;
  localparam int SH    = N_W + $clog2(IMG);
  localparam int M_W   = N_W + 1;
  localparam int P_W   = N_W + M_W;
  localparam int SCALE = VIEW * 128;
  localparam logic [63:0] RECIP = (64'd1 << SH) / IMG;

  logic signed [14:0] twoc;
  logic signed [14:0] k;
  logic [13:0]        kmag;
  logic [P_W-1:0]     prod;
  logic [N_W-1:0]     rem;
  logic [N_W-1:0]     q;

  logic [N_W-1:0] na, nb, qb;
  logic           nega, negb;

  always_comb begin
    twoc = signed'({5'b0, coord, 1'b0});
    k    = FLIP ? (15'(IMG) - twoc) : (twoc - 15'(IMG));
    kmag = 14'(k[14] ? -k : k);
    prod = P_W'(na) * P_W'(RECIP[M_W-1:0]);
    rem  = nb - N_W'(44'(qb) * 44'(IMG));
    q    = qb + N_W'(rem >= N_W'(IMG));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na   <= N_W'(32'(kmag) * 32'(SCALE));
      nega <= k[14];
      nb   <= na;
      qb   <= N_W'(prod >> SH);
      negb <= nega;
      v    <= negb ? -signed'(VX_W'(q)) : signed'(VX_W'(q));
    end
  end

endmodule

### rtl/core/rsp_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per stage.
// Depends on rsp_pkg.
module rsp_sqrt_cell import rsp_pkg::*; #(
  parameter int BIT = 0,
  parameter int SW  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  logic [SQ_RW-1:0] in_rem,
  input  logic [SQ_W-1:0]  in_root,
  input  logic [SW-1:0]    in_side,
  output logic             out_v,
  output logic [SQ_RW-1:0] out_rem,
  output logic [SQ_W-1:0]  out_root,
  output logic [SW-1:0]    out_side
);

  logic [SQ_RW-1:0] trial;
  logic             take;

  assign trial = (SQ_RW'(in_root) << (BIT + 1)) | (SQ_RW'(1) << (2 * BIT));
  assign take  = in_rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= take ? in_rem - trial : in_rem;
      out_root <= in_root | (take ? (SQ_W'(1) << BIT) : '0);
      out_side <= in_side;
    end
  end

endmodule

### rtl/core/rsp_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit.
// Depends on rsp_pkg.
module rsp_div_cell import rsp_pkg::*; #(
  parameter int BIT = 0,
  parameter int SW  = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_v,
  input  logic [DIV_RW-1:0] in_rem,
  input  logic [DQ_W-1:0]   in_quo,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SW-1:0]     in_side,
  output logic              out_v,
  output logic [DIV_RW-1:0] out_rem,
  output logic [DQ_W-1:0]   out_quo,
  output logic [DEN_W-1:0]  out_den,
  output logic [SW-1:0]     out_side
);

  logic [DIV_RW-1:0] trial;
  logic              take;

  assign trial = DIV_RW'(in_den) << BIT;
  assign take  = in_rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= take ? in_rem - trial : in_rem;
      out_quo  <= in_quo | (take ? (DQ_W'(1) << BIT) : '0);
      out_den  <= in_den;
      out_side <= in_side;
    end
  end

endmodule

### rtl/core/ray_sphere_pixel_intersect.sv
// Ray-sphere hit test, one pixel word per clock while the skid stage holds no result. The
// pipe runs through the viewport map, the dot-product and discriminant stages, 48 square-root
// cells, a setup stage, 15 divider cells and the output register; the 48-cell root chain is
// the longest part. A skid stage behind the output register keeps s_tready registered.
module ray_sphere_pixel_intersect import rsp_pkg::*; #(
  parameter int IMG_WIDTH   = IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT  = IMG_HEIGHT_DEF,
  parameter int VIEW_WIDTH  = VIEW_WIDTH_DEF,
  parameter int VIEW_HEIGHT = VIEW_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // pixel_col, pixel_row
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // pixel_address, pixel_color, hit_distance
  output logic              m_tuser,   // write_pixel
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic signed [15:0] camera_x, camera_y, camera_z;
  logic signed [15:0] sphere_x, sphere_y, sphere_z, view_distance;
  logic [14:0]        sphere_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x      <= '0;
      camera_y      <= '0;
      camera_z      <= '0;
      sphere_x      <= '0;
      sphere_y      <= '0;
      sphere_z      <= 16'sd10;
      sphere_radius <= 15'd1;
      view_distance <= 16'sd1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_CAMERA_X:      camera_x      <= cfg_wdata;
        REG_CAMERA_Y:      camera_y      <= cfg_wdata;
        REG_CAMERA_Z:      camera_z      <= cfg_wdata;
        REG_SPHERE_X:      sphere_x      <= cfg_wdata;
        REG_SPHERE_Y:      sphere_y      <= cfg_wdata;
        REG_SPHERE_Z:      sphere_z      <= cfg_wdata;
        REG_SPHERE_RADIUS: sphere_radius <= cfg_wdata[14:0];
        REG_VIEW_DISTANCE: view_distance <= cfg_wdata;
      endcase
    end
  end

  logic en;
  logic skid_v;
  assign en       = !skid_v;
  assign s_tready = en;

  logic [ADDR_W-1:0]      addr_in;
  logic [2:0]             vm_v;
  logic [ADDR_W-1:0]      vm_addr [0:2];
  logic signed [VX_W-1:0] vx, vy;

  assign addr_in = ADDR_W'(ADDR_W'(s_tdata[17:9]) * ADDR_W'(IMG_WIDTH) + ADDR_W'(s_tdata[8:0]));

  rsp_view_map #(.IMG(IMG_WIDTH), .VIEW(VIEW_WIDTH), .FLIP(1'b0)) u_map_x (
    .clk(clk), .en(en), .coord(s_tdata[8:0]), .v(vx)
  );

  rsp_view_map #(.IMG(IMG_HEIGHT), .VIEW(VIEW_HEIGHT), .FLIP(1'b1)) u_map_y (
    .clk(clk), .en(en), .coord(s_tdata[17:9]), .v(vy)
  );

  logic d_v, e_v, f_v, g_v, h_v, i_v;
  logic [ADDR_W-1:0] d_addr, e_addr, f_addr, g_addr, h_addr;

  logic signed [D_W-1:0] dx, dy, dz;
  logic signed [E_W-1:0] ex, ey, ez;

  logic signed [63:0]    pxx, pyy, pzz;
  logic signed [B_W-1:0] pbx, pby, pbz;
  logic signed [C_W-1:0] exx, eyy, ezz;
  logic [29:0]           rr;

  logic [A_W-1:0]        fa;
  logic signed [B_W-1:0] fb;
  logic signed [C_W-1:0] fc;

  logic [47:0] bmag;
  logic [35:0] cmag;
  logic [47:0] pbhh, pbhl, pbll, pchh, pchl, pclh, pcll;
  logic        g_cle0, g_azero, h_cle0, h_azero;
  logic [A_W-1:0] g_a, h_a;
  logic [B_W-1:0] g_b, h_b;

  logic [95:0] b2;
  logic [97:0] ac;
  logic signed [DISC_W-1:0] ac4, disc;
  logic        i_miss;

  logic [SQ_RW-1:0] i_rem;
  sq_side_t         i_side;

  always_comb begin
    bmag   = 48'(fb[B_W-1] ? -fb : fb);
    cmag   = 36'(fc[C_W-1] ? -fc : fc);
    ac4    = DISC_W'(ac) << 2;
    disc   = h_cle0 ? DISC_W'(b2) + ac4 : DISC_W'(b2) - ac4;
    i_miss = h_azero | disc[DISC_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm_v <= '0;
      d_v  <= 1'b0;
      e_v  <= 1'b0;
      f_v  <= 1'b0;
      g_v  <= 1'b0;
      h_v  <= 1'b0;
      i_v  <= 1'b0;
    end else if (en) begin
      vm_v <= {vm_v[1:0], s_tvalid};
      d_v  <= vm_v[2];
      e_v  <= d_v;
      f_v  <= e_v;
      g_v  <= f_v;
      h_v  <= g_v;
      i_v  <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vm_addr[0] <= addr_in;
      vm_addr[1] <= vm_addr[0];
      vm_addr[2] <= vm_addr[1];

      dx     <= D_W'(vx) - (D_W'(camera_x) <<< 8);
      dy     <= D_W'(vy) - (D_W'(camera_y) <<< 8);
      dz     <= (D_W'(view_distance) - D_W'(camera_z)) <<< 8;
      ex     <= E_W'(camera_x) - E_W'(sphere_x);
      ey     <= E_W'(camera_y) - E_W'(sphere_y);
      ez     <= E_W'(camera_z) - E_W'(sphere_z);
      d_addr <= vm_addr[2];

      pxx    <= dx * dx;
      pyy    <= dy * dy;
      pzz    <= dz * dz;
      pbx    <= dx * ex;
      pby    <= dy * ey;
      pbz    <= dz * ez;
      exx    <= ex * ex;
      eyy    <= ey * ey;
      ezz    <= ez * ez;
      rr     <= sphere_radius * sphere_radius;
      e_addr <= d_addr;

      fa     <= A_W'(pxx + pyy + pzz);
      fb     <= (pbx + pby + pbz) <<< 1;
      fc     <= exx + eyy + ezz - signed'(C_W'(rr));
      f_addr <= e_addr;

      pbhh    <= bmag[47:24] * bmag[47:24];
      pbhl    <= bmag[47:24] * bmag[23:0];
      pbll    <= bmag[23:0] * bmag[23:0];
      pchh    <= fa[59:30] * cmag[35:18];
      pchl    <= fa[59:30] * cmag[17:0];
      pclh    <= fa[29:0] * cmag[35:18];
      pcll    <= fa[29:0] * cmag[17:0];
      g_cle0  <= fc[C_W-1] || (fc == '0);
      g_azero <= (fa == '0);
      g_a     <= fa;
      g_b     <= fb;
      g_addr  <= f_addr;

      b2      <= (96'(pbhh) << 48) + (96'(pbhl) << 25) + 96'(pbll);
      ac      <= (98'(pchh) << 48) + (98'(pchl) << 30) + (98'(pclh) << 18) + 98'(pcll);
      h_cle0  <= g_cle0;
      h_azero <= g_azero;
      h_a     <= g_a;
      h_b     <= g_b;
      h_addr  <= g_addr;

      i_rem       <= i_miss ? '0 : SQ_RW'(disc[95:0]);
      i_side.addr <= h_addr;
      i_side.b    <= h_b;
      i_side.a    <= h_a;
      i_side.miss <= i_miss;
    end
  end

  logic             sq_v    [0:SQ_W];
  logic [SQ_RW-1:0] sq_rem  [0:SQ_W];
  logic [SQ_W-1:0]  sq_root [0:SQ_W];
  sq_side_t         sq_side [0:SQ_W];

  assign sq_v[0]    = i_v;
  assign sq_rem[0]  = i_rem;
  assign sq_root[0] = '0;
  assign sq_side[0] = i_side;

  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    rsp_sqrt_cell #(.BIT(SQ_W - 1 - k), .SW($bits(sq_side_t))) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_v(sq_v[k]), .in_rem(sq_rem[k]), .in_root(sq_root[k]), .in_side(sq_side[k]),
      .out_v(sq_v[k+1]), .out_rem(sq_rem[k+1]), .out_root(sq_root[k+1]),
      .out_side(sq_side[k+1])
    );
  end

  sq_side_t                sq_last;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-2:0]        nmag;
  logic [DEN_W-1:0]        den;
  logic                    j_v;
  logic [DIV_RW-1:0]       j_rem;
  logic [DEN_W-1:0]        j_den;
  dv_side_t                j_side;

  always_comb begin
    sq_last = sq_side[SQ_W];
    num     = (-NUM_W'(signed'(sq_last.b)) - signed'(NUM_W'(sq_root[SQ_W]))) <<< 8;
    nmag    = (NUM_W - 1)'(num[NUM_W-1] ? -num : num);
    den     = {sq_last.a, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j_v <= 1'b0;
    end else if (en) begin
      j_v <= sq_v[SQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_rem       <= DIV_RW'(nmag);
      j_den       <= den;
      j_side.addr <= sq_last.addr;
      j_side.neg  <= num[NUM_W-1];
      j_side.ovf  <= DIV_RW'(nmag) >= (DIV_RW'(den) << DQ_W);
      j_side.miss <= sq_last.miss;
    end
  end

  logic              dv_v    [0:DQ_W];
  logic [DIV_RW-1:0] dv_rem  [0:DQ_W];
  logic [DQ_W-1:0]   dv_quo  [0:DQ_W];
  logic [DEN_W-1:0]  dv_den  [0:DQ_W];
  dv_side_t          dv_side [0:DQ_W];

  assign dv_v[0]    = j_v;
  assign dv_rem[0]  = j_rem;
  assign dv_quo[0]  = '0;
  assign dv_den[0]  = j_den;
  assign dv_side[0] = j_side;

  for (genvar k = 0; k < DQ_W; k++) begin : g_div
    rsp_div_cell #(.BIT(DQ_W - 1 - k), .SW($bits(dv_side_t))) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_v(dv_v[k]), .in_rem(dv_rem[k]), .in_quo(dv_quo[k]), .in_den(dv_den[k]),
      .in_side(dv_side[k]),
      .out_v(dv_v[k+1]), .out_rem(dv_rem[k+1]), .out_quo(dv_quo[k+1]),
      .out_den(dv_den[k+1]), .out_side(dv_side[k+1])
    );
  end

  dv_side_t           dv_last;
  logic signed [15:0] t;
  logic [31:0]        color;
  logic [65:0]        pipe_d;
  logic               pipe_u;
  logic               pipe_v;

  always_comb begin
    dv_last = dv_side[DQ_W];
    priority if (dv_last.miss) begin
      t = '0;
    end else if (dv_last.ovf) begin
      t = dv_last.neg ? 16'sh8000 : 16'sh7FFF;
    end else begin
      t = dv_last.neg ? -signed'(16'(dv_quo[DQ_W])) : signed'(16'(dv_quo[DQ_W]));
    end
    priority if (t == '0) begin
      color = GREY_COLOR;
    end else if (t[15]) begin
      color = '0;
    end else begin
      color = LIGHT_COLOR;
    end
    pipe_d = {t, color, dv_last.addr};
    pipe_u = !t[15];
    pipe_v = dv_v[DQ_W];
  end

  logic [65:0] out_d, skid_d;
  logic        out_u, skid_u;
  logic        take;

  assign take = m_tready || !m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (take) begin
      m_tvalid <= skid_v || pipe_v;
      skid_v   <= 1'b0;
    end else if (pipe_v && en) begin
      skid_v   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_d <= skid_v ? skid_d : pipe_d;
      out_u <= skid_v ? skid_u : pipe_u;
    end else if (en) begin
      skid_d <= pipe_d;
      skid_u <= pipe_u;
    end
  end

  assign m_tdata = {6'b0, out_d};
  assign m_tuser = out_u;

endmodule

### rtl/core/rsp_checker.sv
// Port-level checks on the result stream of the ray-sphere pixel block.
// Depends on rsp_pkg; bound to ray_sphere_pixel_intersect.
module rsp_checker import rsp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  a_skip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[49:18] == 32'd0 && m_tdata[65])
    else $error("dropped pixel without negative distance and blank colour");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[65:50] == 16'd0) == (m_tdata[49:18] == GREY_COLOR))
    else $error("grey colour does not match zero distance");

  a_light: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && m_tdata[65:50] != 16'd0 |-> m_tdata[49:18] == LIGHT_COLOR)
    else $error("hit without light colour");

endmodule

bind ray_sphere_pixel_intersect rsp_checker u_rsp_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);
